@@ design/lpdib_pkg.sv @@
// ----------------------------------------------------------------------------
// lpdib_pkg
// Shared types and constants of the lidar range-image binner.
// ----------------------------------------------------------------------------
package lpdib_pkg;

    // Input modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_VIEW = 2'd1;
    localparam logic [1:0] STAT_CHAN = 2'd2;
    localparam logic [1:0] STAT_COL  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_ANGLE_MIN = 3'd0;
    localparam logic [2:0] CFG_ANGLE_MAX = 3'd1;
    localparam logic [2:0] CFG_RES       = 3'd2;
    localparam logic [2:0] CFG_ROWS      = 3'd3;
    localparam logic [2:0] CFG_TOP_DOWN  = 3'd4;
    localparam logic [2:0] CFG_MAX_RANGE = 3'd5;

    // 18000/pi in Q16: radians Q16 to centidegrees Q32
    localparam logic signed [29:0] RAD_TO_CDEG = 30'sd375493621;
    // Full turn in centidegrees
    localparam logic signed [19:0] FULL_TURN   = 20'sd36000;
    localparam logic [15:0]        DEPTH_FULL  = 16'hFFFF;

    // Work for the back end
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_POINT = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  status;
        logic [5:0]  row;
        logic [9:0]  column;
        logic [6:0]  arow;
        logic [16:0] dint;
        logic [16:0] span;
        logic [15:0] res;
        logic [36:0] num;
        logic [19:0] den;
    } entry_t;

endpackage

@@ design/lpdib_ram.sv @@
// ----------------------------------------------------------------------------
// lpdib_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpdib_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lpdib_div.sv @@
// ----------------------------------------------------------------------------
// lpdib_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpdib_div #(
    parameter int N_W = 17,
    parameter int D_W = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           busy,
    output logic [N_W-1:0] quo
);

    localparam int CW = $clog2(N_W + 1);

    logic           busy_reg;
    logic [CW-1:0]  cnt_reg;
    logic [N_W-1:0] quo_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] den_reg;
    logic [D_W:0]   rem_sh;
    logic           ge;
    logic [D_W:0]   rem_new;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[N_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(N_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N_W-2:0], ge};
            rem_reg <= rem_new[D_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

@@ design/lpdib_queue.sv @@
// ----------------------------------------------------------------------------
// lpdib_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module lpdib_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpdib_pkg::entry_t din,
    output logic              full,
    input  logic              pop,
    output lpdib_pkg::entry_t head,
    output logic              empty
);

    lpdib_pkg::entry_t slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

    assign head  = slot_reg[rptr_reg];
    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;

endmodule

@@ design/lpdib_front.sv @@
// ----------------------------------------------------------------------------
// lpdib_front
// Configuration registers and two-stage classifier: row, view, divider
// operands.
// ----------------------------------------------------------------------------
module lpdib_front #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [15:0]        channel,
    input  logic signed [19:0] azimuth,
    input  logic [19:0]        distance_mm,
    input  logic [5:0]         read_row,
    input  logic [9:0]         read_column,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               init,
    input  logic               q_full,
    output logic               q_push,
    output lpdib_pkg::entry_t  q_din
);

    // Configuration
    logic signed [16:0] amin_reg;
    logic signed [16:0] amax_reg;
    logic [15:0]        res_reg;
    logic [6:0]         rowcnt_reg;
    logic               t2d_reg;
    logic [19:0]        maxr_reg;

    // Stage A
    logic               va_reg;
    logic               va_next;
    logic [1:0]         mode_a;
    logic [15:0]        chan_a;
    logic signed [19:0] az_a;
    logic [19:0]        dist_a;
    logic [5:0]         rr_a;
    logic [9:0]         rc_a;

    // Stage B
    logic               vb_reg;
    logic               vb_next;
    logic [1:0]         mode_b;
    logic               chbad_b;
    logic [6:0]         row_b;
    logic signed [49:0] prod_b;
    logic [19:0]        dist_b;
    logic [5:0]         rr_b;
    logic [9:0]         rc_b;

    logic               adv_a;
    logic               adv_b;
    logic               accept;
    logic [8:0]         rows_w;
    logic [6:0]         rows7;
    logic               chbad_a;
    logic [6:0]         row_a;
    logic signed [49:0] prod_a;

    logic               wrap;
    logic signed [19:0] amin20;
    logic signed [19:0] hi_i;
    logic signed [51:0] p52;
    logic signed [51:0] lo52;
    logic signed [51:0] hi52;
    logic signed [51:0] diff;
    logic               in_view;
    logic [19:0]        span20;
    logic [19:0]        m;
    logic               read_bad;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amin_reg   <= 17'sd0;
            amax_reg   <= 17'sd36000;
            res_reg    <= 16'd36;
            rowcnt_reg <= 7'd64;
            t2d_reg    <= 1'b1;
            maxr_reg   <= 20'd200000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpdib_pkg::CFG_ANGLE_MIN: amin_reg   <= cfg_data[16:0];
                lpdib_pkg::CFG_ANGLE_MAX: amax_reg   <= cfg_data[16:0];
                lpdib_pkg::CFG_RES:       res_reg    <= cfg_data[15:0];
                lpdib_pkg::CFG_ROWS:      rowcnt_reg <= cfg_data[6:0];
                lpdib_pkg::CFG_TOP_DOWN:  t2d_reg    <= cfg_data[0];
                lpdib_pkg::CFG_MAX_RANGE: maxr_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Advance the pipe when the next place frees up
    always_comb
    begin
        adv_b    = !vb_reg || !q_full;
        adv_a    = !va_reg || adv_b;
        in_stall = !adv_a || init;
        accept   = in_valid && !in_stall;
        q_push   = vb_reg && !q_full;
        va_next  = adv_a ? accept : va_reg;
        vb_next  = adv_b ? va_reg : vb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    // Stage A: row from channel, azimuth to centidegrees
    always_comb
    begin
        rows_w  = ({2'b00, rowcnt_reg} < 9'(MAX_ROWS)) ? {2'b00, rowcnt_reg} : 9'(MAX_ROWS);
        rows7   = rows_w[6:0];
        chbad_a = chan_a >= {9'd0, rows7};
        row_a   = t2d_reg ? chan_a[6:0] : (rows7 - 7'd1 - chan_a[6:0]);
        prod_a  = 50'(az_a) * 50'(lpdib_pkg::RAD_TO_CDEG);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_a <= mode;
            chan_a <= channel;
            az_a   <= azimuth;
            dist_a <= distance_mm;
            rr_a   <= read_row;
            rc_a   <= read_column;
        end
        if (adv_b && va_reg)
        begin
            mode_b  <= mode_a;
            chbad_b <= chbad_a;
            row_b   <= row_a;
            prod_b  <= prod_a;
            dist_b  <= dist_a;
            rr_b    <= rr_a;
            rc_b    <= rc_a;
        end
    end

    // Stage B: view window, column and depth operands
    always_comb
    begin
        wrap     = amin_reg > amax_reg;
        amin20   = 20'(amin_reg);
        hi_i     = 20'(amax_reg) + (wrap ? lpdib_pkg::FULL_TURN : 20'sd0);
        p52      = 52'(prod_b) + (wrap ? {lpdib_pkg::FULL_TURN, 32'd0} : 52'sd0);
        lo52     = {amin20, 32'd0};
        hi52     = {hi_i, 32'd0};
        in_view  = (p52 > lo52) && (p52 <= hi52);
        diff     = p52 - lo52;
        span20   = (hi_i > amin20) ? 20'(hi_i - amin20) : 20'd0;
        m        = (dist_b < maxr_reg) ? dist_b : maxr_reg;
        read_bad = (32'(rr_b) >= 32'(MAX_ROWS)) || (32'(rc_b) >= 32'(MAX_COLUMNS));

        q_din        = '0;
        q_din.dint   = diff[48:32];
        q_din.span   = span20[16:0];
        q_din.res    = (res_reg == 16'd0) ? 16'd1 : res_reg;
        q_din.num    = 37'(m) * 37'(lpdib_pkg::DEPTH_FULL) + 37'(maxr_reg) - 37'd1;
        q_din.den    = maxr_reg;
        q_din.op     = lpdib_pkg::OP_NONE;
        q_din.status = lpdib_pkg::STAT_DONE;
        unique case (mode_b)
            lpdib_pkg::MODE_CLEAR:
            begin
                q_din.op = lpdib_pkg::OP_CLEAR;
            end
            lpdib_pkg::MODE_POINT:
            begin
                priority if (chbad_b)
                begin
                    q_din.status = lpdib_pkg::STAT_CHAN;
                end
                else if (!in_view)
                begin
                    q_din.status = lpdib_pkg::STAT_VIEW;
                    q_din.row    = row_b[5:0];
                end
                else
                begin
                    q_din.op   = lpdib_pkg::OP_POINT;
                    q_din.row  = row_b[5:0];
                    q_din.arow = row_b;
                end
            end
            lpdib_pkg::MODE_READ:
            begin
                q_din.row    = rr_b;
                q_din.column = rc_b;
                q_din.arow   = {1'b0, rr_b};
                if (read_bad)
                begin
                    q_din.status = lpdib_pkg::STAT_COL;
                end
                else
                begin
                    q_din.op = lpdib_pkg::OP_READ;
                end
            end
            default:
            begin
                q_din.op = lpdib_pkg::OP_NONE;
            end
        endcase
    end

endmodule

@@ design/lpdib_back.sv @@
// ----------------------------------------------------------------------------
// lpdib_back
// Executes queued work: store sweep, pixel read, point divide and write,
// and holds the result register.
// ----------------------------------------------------------------------------
module lpdib_back #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  lpdib_pkg::entry_t q_head,
    output logic              q_pop,
    output logic              init,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [5:0]        row,
    output logic [9:0]        column,
    output logic [15:0]       depth
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CLEAR = 6'b000100,
        ST_RDATA = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [AW-1:0]  ctr_reg;
    logic [AW-1:0]  ctr_next;
    logic           ov_reg;
    logic           ov_next;

    logic [1:0]     pst_reg;
    logic [5:0]     prow_reg;
    logic [9:0]     pcol_reg;
    logic [15:0]    pdep_reg;
    logic [6:0]     parow_reg;
    logic           pzero_reg;

    logic [1:0]     st_o_reg;
    logic [5:0]     row_o_reg;
    logic [9:0]     col_o_reg;
    logic [15:0]    dep_o_reg;

    logic           start;
    logic           busy_c;
    logic           busy_w;
    logic           busy_d;
    logic [16:0]    quo_c;
    logic [16:0]    quo_w;
    logic [36:0]    quo_d;

    logic           we;
    logic [AW-1:0]  waddr;
    logic           re;
    logic [AW-1:0]  raddr;
    logic [15:0]    rdata;

    logic           out_free;
    logic           div_done;
    logic [16:0]    w_cl;
    logic           c_beyond;
    logic [15:0]    dep_calc;
    logic [9:0]     col_calc;

    function automatic logic [AW-1:0] pix_addr(input logic [6:0] r, input logic [16:0] c);
        pix_addr = AW'(32'(r) * MAX_COLUMNS + 32'(c));
    endfunction

    // Dividers: column, image width, depth
    lpdib_div #(.N_W(17), .D_W(16)) u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (q_head.dint),
        .den   (q_head.res),
        .busy  (busy_c),
        .quo   (quo_c)
    );

    lpdib_div #(.N_W(17), .D_W(16)) u_div_width (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (q_head.span),
        .den   (q_head.res),
        .busy  (busy_w),
        .quo   (quo_w)
    );

    lpdib_div #(.N_W(37), .D_W(20)) u_div_depth (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (q_head.num),
        .den   (q_head.den),
        .busy  (busy_d),
        .quo   (quo_d)
    );

    // Frame store
    lpdib_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (16'd0 | ((state_reg == ST_DIV) ? dep_calc : 16'd0)),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Finish a point: clamp width, place column, scale depth
    always_comb
    begin
        div_done = !busy_c && !busy_w && !busy_d;
        w_cl     = (32'(quo_w) > 32'(MAX_COLUMNS)) ? 17'(MAX_COLUMNS) : quo_w;
        c_beyond = quo_c >= w_cl;
        dep_calc = pzero_reg ? 16'd0 : (lpdib_pkg::DEPTH_FULL - quo_d[15:0]);
        col_calc = (quo_c > 17'd1023) ? 10'd1023 : quo_c[9:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ctr_next   = ctr_reg;
        q_pop      = 1'b0;
        start      = 1'b0;
        we         = 1'b0;
        waddr      = ctr_reg;
        re         = 1'b0;
        raddr      = pix_addr(q_head.arow, 17'(q_head.column));
        out_free   = !ov_reg || !out_stall;
        ov_next    = ov_reg && out_stall;

        unique case (state_reg)
            ST_INIT:
            begin
                we       = 1'b1;
                ctr_next = ctr_reg + AW'(1);
                if (ctr_reg == AW'(DEPTH - 1))
                begin
                    ctr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.op)
                        lpdib_pkg::OP_NONE:  state_next = ST_EMIT;
                        lpdib_pkg::OP_CLEAR:
                        begin
                            ctr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        lpdib_pkg::OP_READ:
                        begin
                            re         = 1'b1;
                            state_next = ST_RDATA;
                        end
                        lpdib_pkg::OP_POINT:
                        begin
                            start      = 1'b1;
                            state_next = ST_DIV;
                        end
                        default:             state_next = ST_EMIT;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                we       = 1'b1;
                ctr_next = ctr_reg + AW'(1);
                if (ctr_reg == AW'(DEPTH - 1))
                begin
                    ctr_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_RDATA:
            begin
                state_next = ST_EMIT;
            end
            ST_DIV:
            begin
                waddr = pix_addr(parow_reg, quo_c);
                if (div_done)
                begin
                    we         = !c_beyond;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ctr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            ov_reg    <= ov_next;
        end
    end

    // Hold the pending result
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && !q_empty)
        begin
            pst_reg   <= q_head.status;
            prow_reg  <= q_head.row;
            pcol_reg  <= q_head.column;
            pdep_reg  <= 16'd0;
            parow_reg <= q_head.arow;
            pzero_reg <= q_head.den == 20'd0;
        end
        else if (state_reg == ST_RDATA)
        begin
            pdep_reg <= rdata;
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            pdep_reg <= dep_calc;
            pcol_reg <= col_calc;
            pst_reg  <= c_beyond ? lpdib_pkg::STAT_COL : lpdib_pkg::STAT_DONE;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            st_o_reg  <= pst_reg;
            row_o_reg <= prow_reg;
            col_o_reg <= pcol_reg;
            dep_o_reg <= pdep_reg;
        end
    end

    assign init      = state_reg == ST_INIT;
    assign out_valid = ov_reg;
    assign status    = st_o_reg;
    assign row       = row_o_reg;
    assign column    = col_o_reg;
    assign depth     = dep_o_reg;

endmodule

@@ design/lidar_point_depth_image_binner_core.sv @@
// ----------------------------------------------------------------------------
// lidar_point_depth_image_binner_core
// Projects lidar points into a depth image held in an on-chip frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry mode, channel, azimuth, distance and a read address;
//   every beat yields exactly one result beat (status, row, column, depth)
//   in input order. The user must write registers on the cfg port only
//   while idle; the block itself does not enforce it. A front pipe (two
//   stages) classifies each beat and pushes it into a two-entry queue; a
//   back sequencer executes the queue in order. For a point the three
//   dividers run side by side and the depth divider is the slowest of
//   them; a frame start runs a one-pixel-per-cycle clearing sweep of the
//   store. The back end works on one item at a time and pops the next
//   only once the last has been passed to the output register; this
//   sets the throughput.
//   Up to four beats wait in the front stages and the queue.
//   After reset the store is swept to zero with in_stall high. A stalled
//   result stays in the output register while the back end goes on with
//   the next item; in_stall rises once the queue and front stages are full.
// ----------------------------------------------------------------------------
module lidar_point_depth_image_binner_core #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [15:0]        channel,
    input  logic signed [19:0] azimuth,
    input  logic [19:0]        distance_mm,
    input  logic [5:0]         read_row,
    input  logic [9:0]         read_column,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [5:0]         row,
    output logic [9:0]         column,
    output logic [15:0]        depth,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    logic              init;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    lpdib_pkg::entry_t q_din;
    lpdib_pkg::entry_t q_head;

    // Classify beats
    lpdib_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .channel     (channel),
        .azimuth     (azimuth),
        .distance_mm (distance_mm),
        .read_row    (read_row),
        .read_column (read_column),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .init        (init),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_din       (q_din)
    );

    // Decouple front from back
    lpdib_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty)
    );

    // Execute work and drive results
    lpdib_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .init      (init),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .row       (row),
        .column    (column),
        .depth     (depth)
    );

endmodule

@@ design/lpdib_checker.sv @@
// ----------------------------------------------------------------------------
// lpdib_checker
// Port-level checks of the binner, bound to the top level.
// ----------------------------------------------------------------------------
module lpdib_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [5:0]  row,
    input logic [9:0]  column,
    input logic [15:0] depth
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(row) &&
        $stable(column) && $stable(depth))
        else $error("stalled result beat changed");

    // Bad channel gives an empty result
    a_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == lpdib_pkg::STAT_CHAN |->
        row == 6'd0 && column == 10'd0 && depth == 16'd0)
        else $error("channel-invalid result not cleared");

    // Outside the view carries no column or depth
    a_view_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == lpdib_pkg::STAT_VIEW |-> column == 10'd0 && depth == 16'd0)
        else $error("out-of-view result carries column or depth");

    // Store sweep after reset holds off input
    a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_stall)
        else $error("input taken during reset sweep");

endmodule

bind lidar_point_depth_image_binner_core lpdib_checker u_lpdib_checker (.*);
